// ===== design/i2cadm_pkg.sv =====
// Shared types and constants for the I2C converter bus master.
package i2cadm_pkg;

    localparam int CHANNEL_COUNT = 4;

    localparam logic [7:0] ADDR_WR   = 8'h90;
    localparam logic [7:0] ADDR_RD   = 8'h91;
    localparam logic [7:0] CTRL_MASK = 8'h77;

    localparam logic [7:0] HALF_PERIOD_RST = 8'd5;

    // Index of the final received byte: address, control, read address, dummy, then samples.
    localparam logic [2:0] LAST_BYTE = 3'(3 + CHANNEL_COUNT);
    localparam logic [2:0] FIRST_SAMPLE = 3'd4;

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic [0:0] REG_HALF_PERIOD = 1'b0;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_START_A,
        PH_START_B,
        PH_START_C,
        PH_TX_LOW,
        PH_TX_HIGH,
        PH_TACK_LOW,
        PH_TACK_HIGH,
        PH_RX_LOW,
        PH_RX_HIGH,
        PH_MACK_LOW,
        PH_MACK_HIGH,
        PH_REP_LOW,
        PH_STOP_A,
        PH_STOP_B,
        PH_STOP_C
    } t_phase;

    typedef struct packed {
        logic       start_request;
        logic       mode;
        logic [7:0] control_byte;
        logic [7:0] dac_value;
        logic       sda_in;
    } t_in_word;

    typedef struct packed {
        logic       scl_level;
        logic       sda_release;
        logic       busy_res;
        logic       sample_valid;
        logic [1:0] sample_channel;
        logic [7:0] sample_value;
        logic       done_res;
        logic       ack_error;
    } t_out_word;

endpackage

// ===== design/i2cadm_in_if.sv =====
// Input word channel: valid/ready handshake carrying one bus tick.
interface i2cadm_in_if;
    import i2cadm_pkg::*;

    logic     valid;
    logic     ready;
    t_in_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== design/i2cadm_out_if.sv =====
// Output word channel: valid/ready handshake carrying the bus levels of one tick.
interface i2cadm_out_if;
    import i2cadm_pkg::*;

    logic      valid;
    logic      ready;
    t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== design/i2cadm_seq.sv =====
// Bus sequencer: phase state machine, bit/byte counters and shift register.
module i2cadm_seq (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_advance,
    input  i2cadm_pkg::t_in_word  i_word,
    input  logic [7:0]            i_half_period,
    output i2cadm_pkg::t_out_word o_res
);
    import i2cadm_pkg::*;

    t_phase     r_phase, n_phase;
    logic [7:0] r_tick, n_tick;
    logic [2:0] r_bit, n_bit;
    logic [2:0] r_byte, n_byte;
    logic [7:0] r_shift, n_shift;
    logic       r_mode, n_mode;
    logic [7:0] r_ctrl, n_ctrl;
    logic [7:0] r_data, n_data;
    logic       r_err, n_err;

    logic       w_end;
    logic       w_last_rx;
    logic [7:0] w_rx_byte;

    function automatic logic [7:0] f_load(input logic [2:0] byte_idx, input logic mode,
                                          input logic [7:0] ctrl, input logic [7:0] data);
        logic [7:0] v;
        if (byte_idx == 3'd0) begin
            v = ADDR_WR;
        end else if (byte_idx == 3'd1) begin
            v = mode ? (ctrl & CTRL_MASK) : ctrl;
        end else if (mode) begin
            v = data;
        end else begin
            v = ADDR_RD;
        end
        return v;
    endfunction

    // A zero half period behaves as one: the compare is then always true.
    assign w_end     = ({1'b0, r_tick} + 9'd1) >= {1'b0, i_half_period};
    assign w_last_rx = r_byte >= LAST_BYTE;
    assign w_rx_byte = {r_shift[6:0], i_word.sda_in};

    // Next state
    always_comb begin
        n_phase = r_phase;
        n_tick  = r_tick;
        n_bit   = r_bit;
        n_byte  = r_byte;
        n_shift = r_shift;
        n_mode  = r_mode;
        n_ctrl  = r_ctrl;
        n_data  = r_data;
        n_err   = r_err;
        if (r_phase == PH_IDLE) begin
            if (i_word.start_request) begin
                n_mode  = i_word.mode;
                n_ctrl  = i_word.control_byte;
                n_data  = i_word.dac_value;
                n_err   = 1'b0;
                n_bit   = '0;
                n_byte  = '0;
                n_tick  = '0;
                n_shift = ADDR_WR;
                n_phase = PH_START_A;
            end
        end else if (!w_end) begin
            n_tick = r_tick + 8'd1;
        end else begin
            n_tick = '0;
            case (r_phase)
                PH_START_A: n_phase = PH_START_B;
                PH_START_B: n_phase = PH_START_C;
                PH_START_C: n_phase = PH_TX_LOW;
                PH_TX_LOW:  n_phase = PH_TX_HIGH;
                PH_TX_HIGH: begin
                    n_shift = {r_shift[6:0], 1'b0};
                    n_bit   = r_bit + 3'd1;
                    n_phase = (r_bit == 3'd7) ? PH_TACK_LOW : PH_TX_LOW;
                end
                PH_TACK_LOW: n_phase = PH_TACK_HIGH;
                PH_TACK_HIGH: begin
                    if (i_word.sda_in) begin
                        // slave did not acknowledge
                        n_err   = 1'b1;
                        n_phase = PH_STOP_A;
                    end else if (r_mode) begin
                        if (r_byte >= 3'd2) begin
                            n_phase = PH_STOP_A;
                        end else begin
                            n_byte  = r_byte + 3'd1;
                            n_shift = f_load(r_byte + 3'd1, r_mode, r_ctrl, r_data);
                            n_phase = PH_TX_LOW;
                        end
                    end else if (r_byte == 3'd0) begin
                        n_byte  = 3'd1;
                        n_shift = f_load(3'd1, r_mode, r_ctrl, r_data);
                        n_phase = PH_TX_LOW;
                    end else if (r_byte == 3'd1) begin
                        n_byte  = 3'd2;
                        n_shift = f_load(3'd2, r_mode, r_ctrl, r_data);
                        n_phase = PH_REP_LOW;
                    end else begin
                        n_byte  = 3'd3;
                        n_shift = '0;
                        n_phase = PH_RX_LOW;
                    end
                end
                PH_REP_LOW: n_phase = PH_START_A;
                PH_RX_LOW:  n_phase = PH_RX_HIGH;
                PH_RX_HIGH: begin
                    n_shift = w_rx_byte;
                    n_bit   = r_bit + 3'd1;
                    n_phase = (r_bit == 3'd7) ? PH_MACK_LOW : PH_RX_LOW;
                end
                PH_MACK_LOW: n_phase = PH_MACK_HIGH;
                PH_MACK_HIGH: begin
                    if (w_last_rx) begin
                        n_phase = PH_STOP_A;
                    end else begin
                        n_byte  = r_byte + 3'd1;
                        n_shift = '0;
                        n_phase = PH_RX_LOW;
                    end
                end
                PH_STOP_A: n_phase = PH_STOP_B;
                PH_STOP_B: n_phase = PH_STOP_C;
                PH_STOP_C: n_phase = PH_IDLE;
                default:   n_phase = PH_IDLE;
            endcase
        end
    end

    // Outputs: bus levels from the phase at the start of the tick
    always_comb begin
        o_res = '0;
        o_res.scl_level   = 1'b1;
        o_res.sda_release = 1'b1;
        o_res.busy_res    = 1'b1;
        case (r_phase)
            PH_START_A: begin
                o_res.scl_level = 1'b1; o_res.sda_release = 1'b1;
            end
            PH_START_B: begin
                o_res.scl_level = 1'b1; o_res.sda_release = 1'b0;
            end
            PH_START_C: begin
                o_res.scl_level = 1'b0; o_res.sda_release = 1'b0;
            end
            PH_TX_LOW: begin
                o_res.scl_level = 1'b0; o_res.sda_release = r_shift[7];
            end
            PH_TX_HIGH: begin
                o_res.scl_level = 1'b1; o_res.sda_release = r_shift[7];
            end
            PH_TACK_LOW, PH_RX_LOW, PH_REP_LOW: begin
                o_res.scl_level = 1'b0; o_res.sda_release = 1'b1;
            end
            PH_TACK_HIGH, PH_RX_HIGH: begin
                o_res.scl_level = 1'b1; o_res.sda_release = 1'b1;
            end
            // master acks every byte but the last
            PH_MACK_LOW: begin
                o_res.scl_level = 1'b0; o_res.sda_release = w_last_rx;
            end
            PH_MACK_HIGH: begin
                o_res.scl_level = 1'b1; o_res.sda_release = w_last_rx;
            end
            PH_STOP_A: begin
                o_res.scl_level = 1'b0; o_res.sda_release = 1'b0;
            end
            PH_STOP_B: begin
                o_res.scl_level = 1'b1; o_res.sda_release = 1'b0;
            end
            PH_STOP_C: begin
                o_res.scl_level = 1'b1; o_res.sda_release = 1'b1;
                o_res.done_res  = w_end;
                o_res.ack_error = w_end & r_err;
            end
            default: begin
                o_res.busy_res = 1'b0;
            end
        endcase
        if (r_phase == PH_RX_HIGH && w_end && r_bit == 3'd7 && r_byte >= FIRST_SAMPLE) begin
            o_res.sample_valid   = 1'b1;
            o_res.sample_channel = 2'(r_byte - FIRST_SAMPLE);
            o_res.sample_value   = w_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_tick  <= '0;
            r_bit   <= '0;
            r_byte  <= '0;
            r_err   <= 1'b0;
        end else if (i_advance) begin
            r_phase <= n_phase;
            r_tick  <= n_tick;
            r_bit   <= n_bit;
            r_byte  <= n_byte;
            r_err   <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_shift <= n_shift;
            r_mode  <= n_mode;
            r_ctrl  <= n_ctrl;
            r_data  <= n_data;
        end
    end

endmodule

// ===== design/i2c_adc_dac_master_sequencer_core.sv =====
// Top level: I2C converter bus master with word handshakes and APB register.
//
//  channel  | dir | payload                                   | handshake
//  ---------+-----+-------------------------------------------+-------------
//  i_in     | in  | start_request mode control_byte dac_value | valid/ready
//           |     | sda_in                                    |
//  o_out    | out | scl/sda levels, busy, sample, done, error | valid/ready
//  APB      | in  | half_period_ticks at byte address 0       | psel/penable
//
// One word in, one word out; a word is taken every clock while the output
// register is empty or being drained, so the sustained rate is one word per cycle.
// Results are registered: sequencer state and result register update together.
// A stalled output holds its word and stops input acceptance; nothing is lost.
// Synchronous reset puts the bus idle with a half period of five ticks.
module i2c_adc_dac_master_sequencer_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    i2cadm_in_if.sink                         i_in,
    i2cadm_out_if.source                      o_out,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [i2cadm_pkg::PADDR_W-1:0]    paddr,
    input  logic [i2cadm_pkg::PDATA_W-1:0]    pwdata,
    output logic [i2cadm_pkg::PDATA_W-1:0]    prdata,
    output logic                              pready
);
    import i2cadm_pkg::*;

    logic [7:0] r_hp;
    logic       w_sel_hp;
    logic       w_accept;
    logic       r_out_valid;
    t_out_word  r_out;
    t_out_word  w_res;

    assign pready   = 1'b1;
    assign w_sel_hp = paddr[PADDR_W-1] == REG_HALF_PERIOD;
    assign prdata   = w_sel_hp ? PDATA_W'(r_hp) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hp <= HALF_PERIOD_RST;
        end else if (psel && penable && pwrite && w_sel_hp) begin
            r_hp <= pwdata[7:0];
        end
    end

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_accept   = i_in.valid && i_in.ready;

    i2cadm_seq u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_advance     (w_accept),
        .i_word        (i_in.data),
        .i_half_period (r_hp),
        .o_res         (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out <= w_res;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    a_done_not_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.done_res && r_out.sample_valid))
        else $error("done and sample in the same word");

    a_error_with_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.ack_error |-> r_out.done_res)
        else $error("ack error without done");

    a_idle_lines: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.busy_res |-> r_out.scl_level && r_out.sda_release)
        else $error("bus lines not released while idle");

endmodule

// ===== tb/sv/i2cadm_bus_checker.sv =====
// Checker for the I2C converter bus master: predicts each result word and compares it.
module i2cadm_bus_checker
    import i2cadm_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    i2cadm_in_if               i_in_ch,
    i2cadm_out_if              i_out_ch,
    input  logic               i_psel,
    input  logic               i_penable,
    input  logic               i_pwrite,
    input  logic [PADDR_W-1:0] i_paddr,
    input  logic [PDATA_W-1:0] i_pwdata,
    input  logic [PDATA_W-1:0] i_prdata,
    input  logic               i_pready,
    output int                 o_failures,
    output int                 o_pending,
    output int                 o_words,
    output int                 o_samples,
    output int                 o_closed,
    output int                 o_nacked
);
    timeunit 1ns;
    timeprecision 1ps;

    // Shadow of the bus master
    t_phase     bus_phase;
    logic [7:0] half_period;
    logic [7:0] tick_count;
    logic [3:0] bit_count;
    logic [2:0] byte_index;
    logic [7:0] shifter;
    logic       write_mode;
    logic [7:0] ctrl_hold;
    logic [7:0] data_hold;
    logic       nack_seen;

    t_out_word  levels_due[$];

    initial begin
        o_failures = 0;
        o_pending  = 0;
        o_words    = 0;
        o_samples  = 0;
        o_closed   = 0;
        o_nacked   = 0;
    end

    function automatic void load_next_byte();
        case (byte_index)
            3'd0:    shifter = ADDR_WR;
            3'd1:    shifter = write_mode ? (ctrl_hold & CTRL_MASK) : ctrl_hold;
            default: shifter = write_mode ? data_hold : ADDR_RD;
        endcase
    endfunction

    function automatic logic reading_last();
        return byte_index >= LAST_BYTE;
    endfunction

    // One bus tick: levels come from the phase at the start of the tick
    function automatic t_out_word next_bus_levels(input t_in_word w);
        t_out_word r;
        logic [8:0] span;
        r = '0;
        r.scl_level   = 1'b1;
        r.sda_release = 1'b1;
        r.busy_res    = 1'b1;
        span = (half_period == 8'd0) ? 9'd1 : {1'b0, half_period};

        case (bus_phase)
            PH_START_A, PH_TACK_HIGH, PH_RX_HIGH, PH_STOP_C: ;
            PH_START_B, PH_STOP_B: r.sda_release = 1'b0;
            PH_START_C, PH_STOP_A: begin
                r.scl_level   = 1'b0;
                r.sda_release = 1'b0;
            end
            PH_TX_LOW: begin
                r.scl_level   = 1'b0;
                r.sda_release = shifter[7];
            end
            PH_TX_HIGH: r.sda_release = shifter[7];
            PH_TACK_LOW, PH_RX_LOW, PH_REP_LOW: r.scl_level = 1'b0;
            PH_MACK_LOW: begin
                r.scl_level   = 1'b0;
                r.sda_release = reading_last();
            end
            PH_MACK_HIGH: r.sda_release = reading_last();
            default: r.busy_res = 1'b0;
        endcase

        if (bus_phase == PH_IDLE) begin
            if (w.start_request) begin
                write_mode = w.mode;
                ctrl_hold  = w.control_byte;
                data_hold  = w.dac_value;
                nack_seen  = 1'b0;
                bit_count  = '0;
                byte_index = '0;
                tick_count = '0;
                load_next_byte();
                bus_phase  = PH_START_A;
            end
        end else if ({1'b0, tick_count} + 9'd1 < span) begin
            tick_count = tick_count + 8'd1;
        end else begin
            tick_count = '0;
            case (bus_phase)
                PH_START_A: bus_phase = PH_START_B;
                PH_START_B: bus_phase = PH_START_C;
                PH_START_C: bus_phase = PH_TX_LOW;
                PH_TX_LOW:  bus_phase = PH_TX_HIGH;
                PH_TX_HIGH: begin
                    shifter   = {shifter[6:0], 1'b0};
                    bit_count = bit_count + 4'd1;
                    if (bit_count >= 4'd8) begin
                        bit_count = '0;
                        bus_phase = PH_TACK_LOW;
                    end else begin
                        bus_phase = PH_TX_LOW;
                    end
                end
                PH_TACK_LOW: bus_phase = PH_TACK_HIGH;
                PH_TACK_HIGH: begin
                    if (w.sda_in) begin
                        nack_seen = 1'b1;
                        bus_phase = PH_STOP_A;
                    end else if (write_mode) begin
                        if (byte_index >= 3'd2) begin
                            bus_phase = PH_STOP_A;
                        end else begin
                            byte_index = byte_index + 3'd1;
                            load_next_byte();
                            bus_phase = PH_TX_LOW;
                        end
                    end else if (byte_index == 3'd0) begin
                        byte_index = 3'd1;
                        load_next_byte();
                        bus_phase = PH_TX_LOW;
                    end else if (byte_index == 3'd1) begin
                        byte_index = 3'd2;
                        load_next_byte();
                        bus_phase = PH_REP_LOW;
                    end else begin
                        // dummy byte comes first
                        byte_index = 3'd3;
                        shifter    = '0;
                        bus_phase  = PH_RX_LOW;
                    end
                end
                PH_REP_LOW: bus_phase = PH_START_A;
                PH_RX_LOW:  bus_phase = PH_RX_HIGH;
                PH_RX_HIGH: begin
                    shifter   = {shifter[6:0], w.sda_in};
                    bit_count = bit_count + 4'd1;
                    if (bit_count >= 4'd8) begin
                        bit_count = '0;
                        if (byte_index >= FIRST_SAMPLE) begin
                            r.sample_valid   = 1'b1;
                            r.sample_channel = 2'(byte_index - FIRST_SAMPLE);
                            r.sample_value   = shifter;
                        end
                        bus_phase = PH_MACK_LOW;
                    end else begin
                        bus_phase = PH_RX_LOW;
                    end
                end
                PH_MACK_LOW: bus_phase = PH_MACK_HIGH;
                PH_MACK_HIGH: begin
                    if (reading_last()) begin
                        bus_phase = PH_STOP_A;
                    end else begin
                        byte_index = byte_index + 3'd1;
                        shifter    = '0;
                        bus_phase  = PH_RX_LOW;
                    end
                end
                PH_STOP_A: bus_phase = PH_STOP_B;
                PH_STOP_B: bus_phase = PH_STOP_C;
                default: begin
                    r.done_res  = 1'b1;
                    r.ack_error = nack_seen;
                    bus_phase   = PH_IDLE;
                end
            endcase
        end
        return r;
    endfunction

    function automatic void flag_field(input string name, input int unsigned want,
                                       input int unsigned got);
        $display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
        o_failures++;
    endfunction

    function automatic void check_levels(input t_out_word want, input t_out_word got);
        if (want.scl_level !== got.scl_level)
            flag_field("scl_level", want.scl_level, got.scl_level);
        if (want.sda_release !== got.sda_release)
            flag_field("sda_release", want.sda_release, got.sda_release);
        if (want.busy_res !== got.busy_res)
            flag_field("busy_res", want.busy_res, got.busy_res);
        if (want.sample_valid !== got.sample_valid)
            flag_field("sample_valid", want.sample_valid, got.sample_valid);
        if (want.sample_channel !== got.sample_channel)
            flag_field("sample_channel", want.sample_channel, got.sample_channel);
        if (want.sample_value !== got.sample_value)
            flag_field("sample_value", want.sample_value, got.sample_value);
        if (want.done_res !== got.done_res)
            flag_field("done_res", want.done_res, got.done_res);
        if (want.ack_error !== got.ack_error)
            flag_field("ack_error", want.ack_error, got.ack_error);
    endfunction

    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            bus_phase   = PH_IDLE;
            half_period = HALF_PERIOD_RST;
            tick_count  = '0;
            bit_count   = '0;
            byte_index  = '0;
            shifter     = '0;
            write_mode  = 1'b0;
            ctrl_hold   = '0;
            data_hold   = '0;
            nack_seen   = 1'b0;
            levels_due.delete();
        end else begin
            // results first: a word taken this edge cannot come out until the next
            if (i_out_ch.valid && i_out_ch.ready) begin
                if (levels_due.size() == 0) begin
                    $display("%0t ns: result word %h with nothing expected",
                             $time, i_out_ch.data);
                    o_failures++;
                end else begin
                    want = levels_due.pop_front();
                    check_levels(want, i_out_ch.data);
                    if (want.sample_valid) o_samples++;
                    if (want.done_res) o_closed++;
                    if (want.done_res && want.ack_error) o_nacked++;
                end
            end
            if (i_in_ch.valid && i_in_ch.ready) begin
                levels_due.push_back(next_bus_levels(i_in_ch.data));
                o_words++;
            end
            if (i_psel && i_penable && i_pready && i_paddr[PADDR_W-1:2] == REG_HALF_PERIOD) begin
                if (i_pwrite) begin
                    half_period = i_pwdata[7:0];
                end else if (i_prdata !== PDATA_W'(half_period)) begin
                    $display("%0t ns: half period read expected %0h, got %0h",
                             $time, half_period, i_prdata);
                    o_failures++;
                end
            end
        end
        o_pending <= levels_due.size();
    end

endmodule

// ===== tb/sv/i2c_adc_dac_master_sequencer_core_test.sv =====
// Top of the bus master testbench: clock, reset, word and register stimulus, verdict.
module i2c_adc_dac_master_sequencer_core_test;
    timeunit 1ns;
    timeprecision 1ps;
    import i2cadm_pkg::*;

    localparam logic [PADDR_W-1:0] HP_ADDR       = PADDR_W'(REG_HALF_PERIOD) << 2;
    localparam logic [PADDR_W-1:0] UNMAPPED_ADDR = PADDR_W'(4);
    localparam int                 HOLD_CYCLES   = 60;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    int failures, pending, words, samples, closed, nacked;
    int tx_idle_pct, rx_idle_pct;
    int hold_asks, hold_served, hold_left;
    int reg_accesses;

    i2cadm_in_if  in_ch();
    i2cadm_out_if out_ch();

    i2c_adc_dac_master_sequencer_core dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel,
        .penable,
        .pwrite,
        .paddr,
        .pwdata,
        .prdata,
        .pready
    );

    i2cadm_bus_checker u_checker (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_ch    (in_ch),
        .i_out_ch   (out_ch),
        .i_psel     (psel),
        .i_penable  (penable),
        .i_pwrite   (pwrite),
        .i_paddr    (paddr),
        .i_pwdata   (pwdata),
        .i_prdata   (prdata),
        .i_pready   (pready),
        .o_failures (failures),
        .o_pending  (pending),
        .o_words    (words),
        .o_samples  (samples),
        .o_closed   (closed),
        .o_nacked   (nacked)
    );

    always #1 clk = ~clk;

    initial begin
        #1_000_000;
        $display("Timed out waiting for the bus master");
        $display("Regression FAIL");
        $finish;
    end

    // Receiver: random stalls, plus a long hold-off when asked
    initial out_ch.ready = 1'b0;
    always @(negedge clk) begin
        if (hold_left > 0) begin
            out_ch.ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_asks != hold_served) begin
            out_ch.ready <= 1'b0;
            hold_served <= hold_served + 1;
            hold_left <= HOLD_CYCLES - 1;
        end else begin
            out_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    task automatic send_word(input t_in_word w);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= w;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic apb_access(input bit wr, input logic [PADDR_W-1:0] addr,
                              input logic [PDATA_W-1:0] wdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
        reg_accesses++;
    endtask

    // Register writes only with no word in flight
    task automatic quiesce();
        in_ch.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    task automatic set_half_period(input logic [7:0] ticks);
        quiesce();
        apb_access(1'b1, HP_ADDR, PDATA_W'(ticks));
        apb_access(1'b0, HP_ADDR, '0);
    endtask

    // low_pct: chance that SDA reads low, i.e. the slave acks
    function automatic t_in_word random_tick(input int low_pct);
        t_in_word w;
        w.start_request = ($urandom_range(0, 99) < 35);
        w.mode          = 1'($urandom_range(0, 1));
        w.control_byte  = 8'($urandom_range(0, 255));
        w.dac_value     = 8'($urandom_range(0, 255));
        w.sda_in        = ($urandom_range(0, 99) >= low_pct);
        return w;
    endfunction

    // Mostly acked transactions; now and then a noisy stretch with missing acks
    task automatic run_ticks(input int count, input bit squeeze);
        int low_pct;
        low_pct = 94;
        for (int n = 0; n < count; n++) begin
            if (n % 100 == 0) low_pct = ($urandom_range(0, 3) == 0) ? 50 : 94;
            if (squeeze && n == count / 2) hold_asks++;
            send_word(random_tick(low_pct));
        end
    endtask

    initial begin
        t_in_word w;
        in_ch.valid = 1'b0;
        in_ch.data  = '0;
        tx_idle_pct = 15;
        rx_idle_pct = 60;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed words at the reset half period
        send_word('0);
        w = '{start_request: 1'b0, mode: 1'b1, control_byte: 8'hFF, dac_value: 8'hFF,
              sda_in: 1'b1};
        send_word(w);
        // write with every control bit set, so the mask shows
        w = '{start_request: 1'b1, mode: 1'b1, control_byte: 8'hFF, dac_value: 8'hFF,
              sda_in: 1'b0};
        send_word(w);
        // requests while busy are dropped
        for (int k = 0; k < 20; k++) begin
            w = '{start_request: 1'b1, mode: k[0], control_byte: k[1] ? 8'h80 : 8'h00,
                  dac_value: 8'h00, sda_in: 1'b0};
            send_word(w);
        end

        quiesce();
        apb_access(1'b1, UNMAPPED_ADDR, PDATA_W'(1));
        apb_access(1'b0, HP_ADDR, '0);

        set_half_period(8'd1);
        run_ticks(400, 1'b0);

        tx_idle_pct = 60;
        rx_idle_pct = 15;
        set_half_period(8'd0);
        run_ticks(200, 1'b0);
        set_half_period(8'd255);
        run_ticks(80, 1'b0);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        set_half_period(8'd2);
        run_ticks(300, 1'b1);
        set_half_period(8'd1);
        run_ticks(300, 1'b0);

        in_ch.valid <= 1'b0;
        for (int k = 0; k < 100000 && pending != 0; k++) @(negedge clk);
        repeat (4) @(negedge clk);

        $display("Covered %0d bus ticks at half periods 5, 1, 0, 255 and 2; %0d transactions",
                 words, closed);
        $display("closed (%0d on a missing ack), %0d samples read, %0d register accesses",
                 nacked, samples, reg_accesses);
        if (pending != 0)
            $display("%0d result words never arrived", pending);
        if (failures == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/i2cadm_pkg.sv
design/i2cadm_in_if.sv
design/i2cadm_out_if.sv
design/i2cadm_seq.sv
design/i2c_adc_dac_master_sequencer_core.sv
tb/sv/i2cadm_bus_checker.sv
tb/sv/i2c_adc_dac_master_sequencer_core_test.sv
